// ----- rtl/core/pulse_width_bit_decoder_defines.svh -----
// Assertion macros shared by the pulse width bit decoder's checker.
`ifndef PULSE_WIDTH_BIT_DECODER_DEFINES_SVH
`define PULSE_WIDTH_BIT_DECODER_DEFINES_SVH

// Assertion that is checked only while reset is low.
`define PWBD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Assertion that is also checked across reset.
`define PWBD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/core/pwbd_pkg.sv -----
// Types and constants of the pulse width bit decoder.
`default_nettype none

package pwbd_pkg;

   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 24;
   localparam int unsigned OUT_DATA_BITS  = 32;
   localparam int unsigned COUNT_BITS     = 8;

   typedef enum logic [2:0] {
      EV_ZERO     = 3'd0,
      EV_ONE      = 3'd1,
      EV_SYNC     = 3'd2,
      EV_ERROR    = 3'd3,
      EV_NOCHANGE = 3'd4,
      EV_END      = 3'd5
   } event_kind_type;

   localparam logic [CSR_INDEX_BITS-1:0] REG_TOLERANCE  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ZERO_WIDTH = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ONE_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SYNC_WIDTH = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IDLE_LIMIT = 3'd4;

   localparam logic [CSR_DATA_BITS-1:0] TOLERANCE_RESET  = 24'd1000;
   localparam logic [CSR_DATA_BITS-1:0] ZERO_WIDTH_RESET = 24'd2000;
   localparam logic [CSR_DATA_BITS-1:0] ONE_WIDTH_RESET  = 24'd4000;
   localparam logic [CSR_DATA_BITS-1:0] SYNC_WIDTH_RESET = 24'd8000;
   localparam logic [CSR_DATA_BITS-1:0] IDLE_LIMIT_RESET = 24'd8000;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Payload of one result word.
   typedef struct packed {
      event_kind_type             kind;
      logic [OUT_DATA_BITS-1:0]   data;
      logic [COUNT_BITS-1:0]      count;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/core/pulse_width_bit_decoder.sv -----
// Pulse width bit decoder: one line tick per request word, one optional result word.
// Usage
//    Each request word is one tick of the sampled line. req_level_report marks a
//    tick on which the line level req_level is reported. A result word carries an
//    event kind (zero bit, one bit, sync, width error, no change, message end),
//    the shift register contents and the bit count after that event.
//    Settings are written through the csr_ channel, which is always ready; they
//    should only be changed while no result is outstanding.
// Throughput
//    One request word is taken every cycle while req_ready is high. A result
//    is registered in the result register, or in the skid register while rsp_
//    stalls; the tick update, width classification and shift are combinational.
// Stalling
//    A result register and a one-word skid register sit in front of rsp_. While
//    the receiver stalls, ticks are still taken until one more result word waits
//    in the skid register; req_ready falls only when both hold a word.
// Reset
//    Synchronous, active high. The line is taken as low, the tick counter, data
//    and count are cleared, the block is unprimed and the settings return to
//    their defaults. No clearing pass is needed.
`default_nettype none

module pulse_width_bit_decoder #(
   parameter int unsigned DATA_BITS  = 32,
   parameter int unsigned TIMER_BITS = 24
) (
   input  wire                                    clock,
   input  wire                                    reset,
   // Request channel: one word per tick.
   input  wire                                    req_valid,
   output logic                                   req_ready,
   input  wire                                    req_level_report,
   input  wire                                    req_level,
   // Result channel.
   output logic                                   rsp_valid,
   input  wire                                    rsp_ready,
   output logic [2:0]                             rsp_event_kind,
   output logic [pwbd_pkg::OUT_DATA_BITS-1:0]     rsp_message_data,
   output logic [pwbd_pkg::COUNT_BITS-1:0]        rsp_bit_count,
   // Settings write channel.
   input  wire                                    csr_valid,
   output logic                                   csr_ready,
   input  wire  [pwbd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire  [pwbd_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   // Comparisons are made one bit wider than the wider of the tick counter and
   // a setting, so that target plus tolerance never wraps.
   localparam int unsigned CMP_BITS =
      ((TIMER_BITS > pwbd_pkg::CSR_DATA_BITS) ? TIMER_BITS : pwbd_pkg::CSR_DATA_BITS) + 1;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

   // Settings.
   logic [pwbd_pkg::CSR_DATA_BITS-1:0] tolerance_ff;
   logic [pwbd_pkg::CSR_DATA_BITS-1:0] zero_width_ff;
   logic [pwbd_pkg::CSR_DATA_BITS-1:0] one_width_ff;
   logic [pwbd_pkg::CSR_DATA_BITS-1:0] sync_width_ff;
   logic [pwbd_pkg::CSR_DATA_BITS-1:0] idle_limit_ff;

   // Decoder state and its next values.
   logic                             line_high_ff, line_high_in;
   logic [TIMER_BITS-1:0]            since_edge_ff, since_edge_in;
   logic [DATA_BITS-1:0]             shift_data_ff, shift_data_in;
   logic [pwbd_pkg::COUNT_BITS-1:0]  bits_seen_ff, bits_seen_in;
   logic                             primed_ff, primed_in;

   // Output register and skid register.
   logic                  out_valid_ff;
   pwbd_pkg::result_type  out_word_ff;
   logic                  skid_valid_ff;
   pwbd_pkg::result_type  skid_word_ff;

   logic                     req_accept;
   logic                     out_free;
   logic [TIMER_BITS-1:0]    since_inc;
   logic [CMP_BITS-1:0]      width_ext;
   logic [CMP_BITS-1:0]      tol_ext;
   logic                     ended;
   logic                     rise;
   logic                     fall;
   logic                     no_change;
   logic                     is_zero;
   logic                     is_one;
   logic                     is_sync;
   logic                     has_result;
   pwbd_pkg::event_kind_type kind;
   pwbd_pkg::result_type     new_word;
   logic [63:0]              data_wide;

   // True when a width lies strictly inside the tolerance band of a target.
   function automatic logic near_target(input logic [CMP_BITS-1:0] target,
                                        input logic [CMP_BITS-1:0] width,
                                        input logic [CMP_BITS-1:0] tol);
      near_target = (width < target + tol) && (width + tol > target);
   endfunction

   // A request word is refused only while the skid register is occupied.
   assign req_ready  = !skid_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign out_free   = !out_valid_ff || rsp_ready;

   always_comb begin
      // The tick counter advances first and saturates.
      since_inc = (since_edge_ff == TIMER_MAX) ? since_edge_ff : since_edge_ff + 1'b1;
      width_ext = CMP_BITS'(since_inc);
      tol_ext   = CMP_BITS'(tolerance_ff);

      // A primed message completes when the line has idled low for too long.
      ended = primed_ff && !line_high_ff && (width_ext > CMP_BITS'(idle_limit_ff));

      no_change = req_level_report && (req_level == line_high_ff);
      rise      = req_level_report && req_level && !line_high_ff;
      fall      = req_level_report && !req_level && line_high_ff;

      // Targets are tried in the order zero, one, sync.
      is_zero = near_target(CMP_BITS'(zero_width_ff), width_ext, tol_ext);
      is_one  = !is_zero && near_target(CMP_BITS'(one_width_ff), width_ext, tol_ext);
      is_sync = !is_zero && !is_one
                && near_target(CMP_BITS'(sync_width_ff), width_ext, tol_ext);

      line_high_in  = line_high_ff;
      since_edge_in = since_inc;
      shift_data_in = shift_data_ff;
      bits_seen_in  = bits_seen_ff;
      primed_in     = ended ? 1'b0 : primed_ff;

      if (rise) begin
         line_high_in  = 1'b1;
         since_edge_in = '0;
         primed_in     = 1'b1;
      end
      if (fall) begin
         // A zero is always shifted in; a one bit then sets the new low bit.
         line_high_in  = 1'b0;
         since_edge_in = '0;
         shift_data_in = {shift_data_ff[DATA_BITS-2:0], is_one};
         if (is_zero || is_one) begin
            if (bits_seen_ff != pwbd_pkg::COUNT_MAX) begin
               bits_seen_in = bits_seen_ff + 1'b1;
            end
         end else if (is_sync) begin
            bits_seen_in = '0;
         end
      end

      // A classified falling edge takes precedence over a message end, which in
      // turn hides a no-change report on the same tick.
      if (fall) begin
         if (is_zero) begin
            kind = pwbd_pkg::EV_ZERO;
         end else if (is_one) begin
            kind = pwbd_pkg::EV_ONE;
         end else if (is_sync) begin
            kind = pwbd_pkg::EV_SYNC;
         end else begin
            kind = pwbd_pkg::EV_ERROR;
         end
      end else if (ended) begin
         kind = pwbd_pkg::EV_END;
      end else begin
         kind = pwbd_pkg::EV_NOCHANGE;
      end
      has_result = fall || ended || no_change;

      // The result always shows the state as it stands after this tick.
      data_wide      = 64'(shift_data_in);
      new_word.kind  = kind;
      new_word.data  = data_wide[pwbd_pkg::OUT_DATA_BITS-1:0];
      new_word.count = bits_seen_in;
   end

   // Settings registers; writes to indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff  <= pwbd_pkg::TOLERANCE_RESET;
         zero_width_ff <= pwbd_pkg::ZERO_WIDTH_RESET;
         one_width_ff  <= pwbd_pkg::ONE_WIDTH_RESET;
         sync_width_ff <= pwbd_pkg::SYNC_WIDTH_RESET;
         idle_limit_ff <= pwbd_pkg::IDLE_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pwbd_pkg::REG_TOLERANCE:  tolerance_ff  <= csr_data;
            pwbd_pkg::REG_ZERO_WIDTH: zero_width_ff <= csr_data;
            pwbd_pkg::REG_ONE_WIDTH:  one_width_ff  <= csr_data;
            pwbd_pkg::REG_SYNC_WIDTH: sync_width_ff <= csr_data;
            pwbd_pkg::REG_IDLE_LIMIT: idle_limit_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Decoder state advances once per accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_high_ff  <= 1'b0;
         since_edge_ff <= '0;
         shift_data_ff <= '0;
         bits_seen_ff  <= '0;
         primed_ff     <= 1'b0;
      end else if (req_accept) begin
         line_high_ff  <= line_high_in;
         since_edge_ff <= since_edge_in;
         shift_data_ff <= shift_data_in;
         bits_seen_ff  <= bits_seen_in;
         primed_ff     <= primed_in;
      end
   end

   // Output register with a one-word skid register behind it. A new word can
   // only arrive while the skid register is empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= req_accept && has_result;
         end
      end else if (req_accept && has_result) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_word_ff <= skid_valid_ff ? skid_word_ff : new_word;
      end
      if (!out_free && req_accept && has_result) begin
         skid_word_ff <= new_word;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_kind   = out_word_ff.kind;
   assign rsp_message_data = out_word_ff.data;
   assign rsp_bit_count    = out_word_ff.count;

endmodule

`default_nettype wire

// ----- rtl/core/pwbd_checker.sv -----
// Port checker for the pulse width bit decoder, bound to its top level.
`default_nettype none
`include "pulse_width_bit_decoder_defines.svh"

module pwbd_checker (
   input wire                                  clock,
   input wire                                  reset,
   input wire                                  req_ready,
   input wire                                  rsp_valid,
   input wire                                  rsp_ready,
   input wire [2:0]                            rsp_event_kind,
   input wire [pwbd_pkg::OUT_DATA_BITS-1:0]    rsp_message_data,
   input wire [pwbd_pkg::COUNT_BITS-1:0]       rsp_bit_count
);

   `PWBD_ASSERT(a_rsp_held, rsp_valid && !rsp_ready |=> rsp_valid, "result word dropped while stalled")
   `PWBD_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_message_data) && $stable(rsp_bit_count) && $stable(rsp_event_kind), "stalled result word changed")
   `PWBD_ASSERT(a_refuse_only_when_full, !req_ready |-> rsp_valid, "request refused with no result waiting")
   `PWBD_ASSERT(a_ready_after_reset, $past(reset) |-> req_ready && !rsp_valid, "block not empty after reset")
   `PWBD_ASSERT(a_sync_clears_count, rsp_valid && (rsp_event_kind == pwbd_pkg::EV_SYNC) |-> (rsp_bit_count == '0), "sync word with non-zero bit count")

endmodule

bind pulse_width_bit_decoder pwbd_checker u_pwbd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_event_kind   (rsp_event_kind),
   .rsp_message_data (rsp_message_data),
   .rsp_bit_count    (rsp_bit_count)
);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the pulse width bit decoder: directed plan, then random line traffic.
`timescale 1ns / 100ps

module tb_top;

   // The run is stopped here if the handshakes ever hang. The limit leaves a wide
   // margin over the slowest correct run.
   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   // A result leaves through a result register and a skid register, so the settle
   // wait covers a tick that is still in flight.
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned DRAIN_CYCLES  = 8;
   localparam logic [23:0] TICKS_MAX     = '1;
   localparam logic [23:0] SETTING_MAX   = '1;

   // One row of the directed plan: a number of silent ticks, then one tick that
   // carries the given report. Where typed is set, the row's result word is the
   // one written in the row rather than the one the predictor works out.
   typedef struct packed {
      logic [15:0]          quiet;
      logic                 report;
      logic                 level;
      logic                 typed;
      pwbd_pkg::result_type want;
   } plan_row_type;

   localparam int PLAN_ROWS = 24;
   // The plan runs with a tolerance of 5 and targets of 10, 20 and 40 ticks,
   // with an idle limit of 40.
   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      // A low report on a line that is already low, straight after reset.
      '{16'd0,  1'b1, 1'b0, 1'b1, '{pwbd_pkg::EV_NOCHANGE, 32'd0, 8'd0}},
      '{16'd0,  1'b1, 1'b1, 1'b0, '0},
      // A high report on a line that is already high.
      '{16'd0,  1'b1, 1'b1, 1'b1, '{pwbd_pkg::EV_NOCHANGE, 32'd0, 8'd0}},
      // A zero bit of exactly the target width.
      '{16'd8,  1'b1, 1'b0, 1'b0, '0},
      '{16'd0,  1'b1, 1'b1, 1'b0, '0},
      // A one bit just inside the upper edge of its window.
      '{16'd23, 1'b1, 1'b0, 1'b0, '0},
      '{16'd0,  1'b1, 1'b1, 1'b0, '0},
      // A zero bit just inside the lower edge of its window.
      '{16'd5,  1'b1, 1'b0, 1'b0, '0},
      '{16'd0,  1'b1, 1'b1, 1'b0, '0},
      // Exactly on the edge between the zero and one windows: a width error.
      '{16'd14, 1'b1, 1'b0, 1'b0, '0},
      '{16'd0,  1'b1, 1'b1, 1'b0, '0},
      // A sync just inside its lower edge, which clears the bit count.
      '{16'd35, 1'b1, 1'b0, 1'b0, '0},
      '{16'd0,  1'b1, 1'b1, 1'b0, '0},
      // Exactly on the upper edge of the sync window: a width error.
      '{16'd44, 1'b1, 1'b0, 1'b0, '0},
      // The line idles low past the limit, so the message ends in the silence.
      '{16'd50, 1'b0, 1'b0, 1'b0, '0},
      // No longer armed: a low report now only gives a no-change word.
      '{16'd0,  1'b1, 1'b0, 1'b0, '0},
      '{16'd0,  1'b1, 1'b1, 1'b0, '0},
      '{16'd9,  1'b1, 1'b0, 1'b0, '0},
      // Low for exactly the idle limit is not yet the end of the message.
      '{16'd39, 1'b1, 1'b0, 1'b0, '0},
      // The end falls on a no-change report, which then gives no word of its own.
      '{16'd0,  1'b1, 1'b0, 1'b0, '0},
      '{16'd0,  1'b1, 1'b1, 1'b0, '0},
      '{16'd19, 1'b1, 1'b0, 1'b0, '0},
      // The end falls on a rising edge, which still raises the line and primes.
      '{16'd40, 1'b1, 1'b1, 1'b0, '0},
      '{16'd9,  1'b1, 1'b0, 1'b0, '0}
   };

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_level_report = 1'b0;
   logic        req_level        = 1'b0;
   logic        rsp_ready        = 1'b0;
   logic        csr_valid        = 1'b0;
   logic [pwbd_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [pwbd_pkg::CSR_DATA_BITS-1:0]  csr_data  = '0;
   logic        req_ready;
   logic        rsp_valid;
   logic        csr_ready;
   logic [2:0]                          rsp_event_kind;
   logic [pwbd_pkg::OUT_DATA_BITS-1:0]  rsp_message_data;
   logic [pwbd_pkg::COUNT_BITS-1:0]     rsp_bit_count;

   // The testbench's own copy of the settings and of the decoder's state.
   logic [23:0] cfg_tol  = pwbd_pkg::TOLERANCE_RESET;
   logic [23:0] cfg_zero = pwbd_pkg::ZERO_WIDTH_RESET;
   logic [23:0] cfg_one  = pwbd_pkg::ONE_WIDTH_RESET;
   logic [23:0] cfg_sync = pwbd_pkg::SYNC_WIDTH_RESET;
   logic [23:0] cfg_idle = pwbd_pkg::IDLE_LIMIT_RESET;
   logic        line_is_high     = 1'b0;
   logic [23:0] ticks_since_edge = '0;
   logic [31:0] shift_word       = '0;
   logic [7:0]  bit_total        = '0;
   logic        armed            = 1'b0;

   pwbd_pkg::result_type awaited_events [$];
   int unsigned ticks_sent    = 0;
   int unsigned mismatches    = 0;
   int unsigned cycle_count   = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_idle_pct  = 0;

   pulse_width_bit_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_level_report (req_level_report),
      .req_level        (req_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_message_data (rsp_message_data),
      .rsp_bit_count    (rsp_bit_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // A width matches a target when it lies strictly within the tolerance of it.
   // The sums can pass 24 bits, so the comparison is made one bit wider.
   function automatic bit in_window(input logic [23:0] target, input logic [23:0] width);
      logic [24:0] t;
      logic [24:0] w;
      logic [24:0] tol;
      t   = target;
      w   = width;
      tol = cfg_tol;
      return (w < t + tol) && (w + tol > t);
   endfunction

   // Advances the copy of the decoder by one tick and works out the word, if
   // any, that the tick causes. Returns whether a word is due.
   function automatic bit decode_tick(input logic rep, input logic lvl,
                                      output pwbd_pkg::result_type ev);
      bit                       ended;
      bit                       produced;
      logic [23:0]              width;
      pwbd_pkg::event_kind_type kind;
      ended    = 1'b0;
      produced = 1'b0;
      ev       = '0;
      if (ticks_since_edge != TICKS_MAX) begin
         ticks_since_edge++;
      end
      // The message end is tested on the fresh tick count, before the report.
      if (armed && !line_is_high && ticks_since_edge > cfg_idle) begin
         ev       = '{pwbd_pkg::EV_END, shift_word, bit_total};
         armed    = 1'b0;
         ended    = 1'b1;
         produced = 1'b1;
      end
      if (rep) begin
         if (lvl == line_is_high) begin
            // A no-change report loses its word to a message end on the same tick.
            if (!ended) begin
               ev       = '{pwbd_pkg::EV_NOCHANGE, shift_word, bit_total};
               produced = 1'b1;
            end
         end else if (lvl) begin
            line_is_high     = 1'b1;
            ticks_since_edge = '0;
            armed            = 1'b1;
         end else begin
            width      = ticks_since_edge;
            shift_word = {shift_word[30:0], 1'b0};
            if (in_window(cfg_zero, width)) begin
               kind = pwbd_pkg::EV_ZERO;
               if (bit_total != pwbd_pkg::COUNT_MAX) bit_total++;
            end else if (in_window(cfg_one, width)) begin
               kind          = pwbd_pkg::EV_ONE;
               shift_word[0] = 1'b1;
               if (bit_total != pwbd_pkg::COUNT_MAX) bit_total++;
            end else if (in_window(cfg_sync, width)) begin
               kind      = pwbd_pkg::EV_SYNC;
               bit_total = '0;
            end else begin
               kind = pwbd_pkg::EV_ERROR;
            end
            line_is_high     = 1'b0;
            ticks_since_edge = '0;
            ev               = '{kind, shift_word, bit_total};
            produced         = 1'b1;
         end
      end
      return produced;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("%0t: %s", $time, what);
      mismatches++;
   endtask

   // Offers one tick to the decoder, after a random pause, and notes the word it
   // should cause once the tick has been taken.
   task automatic send_tick(input logic rep, input logic lvl,
                            input bit typed, input pwbd_pkg::result_type want);
      int unsigned          gap;
      bit                   produced;
      pwbd_pkg::result_type ev;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_level_report <= rep;
      req_level        <= lvl;
      do @(posedge clock); while (!req_ready);
      ticks_sent++;
      produced = decode_tick(rep, lvl, ev);
      if (typed) begin
         awaited_events.push_back(want);
      end else if (produced) begin
         awaited_events.push_back(ev);
      end
   endtask

   // Ticks without a report; the level pin carries noise that must be ignored.
   task automatic quiet_ticks(input int unsigned n);
      repeat (n) send_tick(1'b0, 1'($urandom_range(0, 1)), 1'b0, '0);
   endtask

   // Writes one setting. The write valid is left high so that a following write
   // carries straight on; the caller lowers it after the last one.
   task automatic write_setting(input logic [pwbd_pkg::CSR_INDEX_BITS-1:0] idx,
                                input logic [pwbd_pkg::CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pwbd_pkg::REG_TOLERANCE:  cfg_tol  = value;
         pwbd_pkg::REG_ZERO_WIDTH: cfg_zero = value;
         pwbd_pkg::REG_ONE_WIDTH:  cfg_one  = value;
         pwbd_pkg::REG_SYNC_WIDTH: cfg_sync = value;
         pwbd_pkg::REG_IDLE_LIMIT: cfg_idle = value;
         default: ;
      endcase
   endtask

   // Lets the decoder drain and settle, then loads a whole new set of settings.
   task automatic apply_settings(input logic [23:0] tol, input logic [23:0] zero_w,
                                 input logic [23:0] one_w, input logic [23:0] sync_w,
                                 input logic [23:0] idle_w);
      req_valid <= 1'b0;
      while (awaited_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_setting(pwbd_pkg::REG_TOLERANCE, tol);
      write_setting(pwbd_pkg::REG_ZERO_WIDTH, zero_w);
      write_setting(pwbd_pkg::REG_ONE_WIDTH, one_w);
      write_setting(pwbd_pkg::REG_SYNC_WIDTH, sync_w);
      write_setting(pwbd_pkg::REG_IDLE_LIMIT, idle_w);
      csr_valid <= 1'b0;
   endtask

   // Picks the width of a high pulse, mostly around one of the targets and
   // reaching out to the exact window edges where the tolerance is small. With
   // bits_only set, the width always falls inside the zero or the one window.
   function automatic int pick_width(input bit bits_only);
      int target;
      int span;
      int w;
      case ($urandom_range(0, bits_only ? 1 : 3))
         0:       target = cfg_zero;
         1:       target = cfg_one;
         2:       target = cfg_sync;
         default: target = $urandom_range(1, 48);
      endcase
      span = (cfg_tol > 8) ? 8 : int'(cfg_tol);
      if (bits_only) span = span - 1;
      w = target - span + int'($urandom_range(0, 2 * span));
      if (w < 1 || w > 64) w = $urandom_range(1, 48);
      return w;
   endfunction

   // One random episode. Most are whole pulses: a low gap, a rising report and
   // a falling report. The gap is sometimes made long enough that the message
   // ends in it, or ends exactly on the rising report. The rest are no-change
   // reports and plain random ticks.
   task automatic random_episode(input bit bits_only);
      int unsigned pick;
      int unsigned gap;
      int          w;
      pick = $urandom_range(0, 99);
      if (bits_only || pick < 80) begin
         if (line_is_high) begin
            send_tick(1'b1, 1'b0, 1'b0, '0);
         end
         if (bits_only || cfg_idle > 60) begin
            gap = bits_only ? 0 : $urandom_range(0, 12);
         end else begin
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
               gap = $urandom_range(0, (cfg_idle > 13) ? 12 : int'(cfg_idle) - 1);
            end else if (pick < 17) begin
               gap = cfg_idle + $urandom_range(1, 3);
            end else begin
               gap = cfg_idle;
            end
         end
         w = pick_width(bits_only);
         quiet_ticks(gap);
         send_tick(1'b1, 1'b1, 1'b0, '0);
         quiet_ticks(w - 1);
         send_tick(1'b1, 1'b0, 1'b0, '0);
      end else if (pick < 90) begin
         send_tick(1'b1, line_is_high, 1'b0, '0);
      end else begin
         send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
      end
   endtask

   task automatic random_phase(input int unsigned quota);
      int unsigned from;
      from = ticks_sent;
      while (ticks_sent - from < quota) random_episode(1'b0);
   endtask

   // Result side: every word taken is checked against the oldest word still
   // awaited, and the ready line is stalled at random for the next cycle. The
   // values read here are those from just before the edge, which is what the
   // handshake at this edge used.
   always @(posedge clock) begin : take_results
      pwbd_pkg::result_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_events.size() == 0) begin
            flag_mismatch($sformatf("unexpected word: kind %0d data %h count %0d",
                                    rsp_event_kind, rsp_message_data, rsp_bit_count));
         end else begin
            due = awaited_events.pop_front();
            if (rsp_event_kind !== due.kind) begin
               flag_mismatch($sformatf("event kind %0d, awaited %s",
                                       rsp_event_kind, due.kind.name()));
            end
            if (rsp_message_data !== due.data) begin
               flag_mismatch($sformatf("message data %h, awaited %h (%s)",
                                       rsp_message_data, due.data, due.kind.name()));
            end
            if (rsp_bit_count !== due.count) begin
               flag_mismatch($sformatf("bit count %0d, awaited %0d (%s)",
                                       rsp_bit_count, due.count, due.kind.name()));
            end
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // First the sender stalls often and the receiver more often still.
      send_idle_pct = 36;
      rsp_idle_pct  = 66;

      // Short targets keep the directed pulses cheap while still reaching every
      // window edge.
      apply_settings(24'd5, 24'd10, 24'd20, 24'd40, 24'd40);
      for (int i = 0; i < PLAN_ROWS; i++) begin
         quiet_ticks(DIRECTED_PLAN[i].quiet);
         send_tick(DIRECTED_PLAN[i].report, DIRECTED_PLAN[i].level,
                   DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
      end

      // Short targets, so that random pulses are cheap, and a short idle limit,
      // so that messages end often.
      apply_settings(24'd2, 24'd5, 24'd10, 24'd16, 24'd24);
      random_phase(80);

      // Now the sender is the slower side. Small settings that still decode: the
      // zero and one windows are a single width each and a message ends after two
      // low ticks. A long run of bits without a sync drives the bit count into
      // saturation and shifts the data word right through.
      send_idle_pct = 66;
      rsp_idle_pct  = 36;
      apply_settings(24'd1, 24'd1, 24'd2, 24'd6, 24'd1);
      repeat (260) random_episode(1'b1);
      random_phase(60);

      // No stalls from here on. An idle limit at its largest: no message ends.
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      apply_settings(24'd3, 24'd6, 24'd13, 24'd24, SETTING_MAX);
      random_phase(60);

      // Every setting at its largest: every falling edge decodes as a zero bit.
      apply_settings(SETTING_MAX, SETTING_MAX, SETTING_MAX, SETTING_MAX, SETTING_MAX);
      random_phase(40);

      req_valid <= 1'b0;
      while (awaited_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
